### rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types and constants shared by the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

   localparam int TimeWidth  = 32;
   localparam int MsWidth    = 16;
   localparam int CsrIdxWidth = 3;

   // register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] CSR_ACTIVE_LEVEL = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BOUNCE_MS    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SHORT_MS     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_LONG_MS      = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_REPEAT_MS    = 3'd4;

   // register reset values
   localparam logic               ACTIVE_LEVEL_RST = 1'b0;
   localparam logic [MsWidth-1:0] BOUNCE_MS_RST    = 16'd50;
   localparam logic [MsWidth-1:0] SHORT_MS_RST     = 16'd500;
   localparam logic [MsWidth-1:0] LONG_MS_RST      = 16'd1000;
   localparam logic [MsWidth-1:0] REPEAT_MS_RST    = 16'd200;

   typedef struct packed {
      logic               active_level;
      logic [MsWidth-1:0] bounce_ms;
      logic [MsWidth-1:0] short_ms;
      logic [MsWidth-1:0] long_ms;
      logic [MsWidth-1:0] repeat_ms;
   } cfg_type;

   typedef struct packed {
      logic just_pressed;
      logic just_released;
      logic short_press;
      logic long_press;
      logic repeat_pulse;
   } flags_type;

   typedef struct packed {
      logic                 level;
      logic [TimeWidth-1:0] last_change;
      logic [TimeWidth-1:0] last_repeat;
      flags_type            flags;
   } state_type;

endpackage

### rtl/bdpc_step.sv
// ----------------------------------------------------------------------------
// bdpc_step
// Next-state logic for one request: debounce, edge detect, hold classify
// and auto-repeat timing.
// ----------------------------------------------------------------------------
module bdpc_step (
   input  bdpc_pkg::cfg_type                  cfg,
   input  bdpc_pkg::state_type                cur,
   input  logic                               raw_level,
   input  logic [bdpc_pkg::TimeWidth-1:0]     now_ms,
   output bdpc_pkg::state_type                nxt,
   output logic                               pressed
);
   import bdpc_pkg::*;

   logic [TimeWidth-1:0] held;
   logic [TimeWidth-1:0] since_repeat;
   logic                 was_pressed;
   logic                 is_pressed;
   logic                 ignore;

   assign held         = now_ms - cur.last_change;
   assign since_repeat = now_ms - cur.last_repeat;
   assign was_pressed  = (cur.level == cfg.active_level);
   assign is_pressed   = (raw_level == cfg.active_level);
   assign ignore       = (raw_level != cur.level) &&
                         (held < {{(TimeWidth-MsWidth){1'b0}}, cfg.bounce_ms});

   always_comb begin
      nxt = cur;
      if (!ignore) begin
         if (raw_level != cur.level) begin
            nxt.last_change = now_ms;
         end
         nxt.level               = raw_level;
         nxt.flags.just_pressed  = 1'b0;
         nxt.flags.just_released = 1'b0;
         if (!was_pressed && is_pressed) begin
            nxt.flags.just_pressed = 1'b1;
         end else if (was_pressed && !is_pressed) begin
            nxt.flags.just_released = 1'b1;
            // a hold between the two limits keeps the earlier flags
            if (held < {{(TimeWidth-MsWidth){1'b0}}, cfg.short_ms}) begin
               nxt.flags.short_press = 1'b1;
            end else if (held > {{(TimeWidth-MsWidth){1'b0}}, cfg.long_ms}) begin
               nxt.flags.long_press = 1'b1;
            end
         end else if (was_pressed && is_pressed) begin
            if (held > {{(TimeWidth-MsWidth){1'b0}}, cfg.long_ms}) begin
               nxt.flags.repeat_pulse = 1'b0;
               if (since_repeat > {{(TimeWidth-MsWidth){1'b0}}, cfg.repeat_ms}) begin
                  nxt.flags.repeat_pulse = 1'b1;
                  nxt.last_repeat        = now_ms;
               end
            end
         end else begin
            nxt.flags.short_press  = 1'b0;
            nxt.flags.long_press   = 1'b0;
            nxt.flags.repeat_pulse = 1'b0;
         end
      end
   end

   assign pressed = (nxt.level == cfg.active_level);

endmodule

### rtl/button_debounce_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit
// Debounces a sampled button level and classifies presses.
//
// Usage: each request carries the raw pin level and a wrapping millisecond
// timestamp; every request yields exactly one response with the debounced
// level, the press and release edge flags, the short and long press flags
// and the repeat pulse. Both channels use valid and stall.
// The response is registered at the edge that takes the request, and the
// state is updated at that same edge. Throughput is one request per cycle
// while the response side is not stalled; the only loop is the state
// register through the subtract and compare logic of the step.
// A stall on the response side holds the response register, and the
// request side stalls only while that register is full and stalled.
// Reset (synchronous) loads the register defaults, marks the button as
// released and clears timestamps and flags. The csr port writes one
// register per cycle; writing active_level also marks the button released.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_raw_level,
   input  logic [bdpc_pkg::TimeWidth-1:0]      req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_pressed,
   output logic                                rsp_just_pressed,
   output logic                                rsp_just_released,
   output logic                                rsp_short_press,
   output logic                                rsp_long_press,
   output logic                                rsp_repeat_pulse,
   input  logic                                csr_write,
   input  logic [bdpc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [bdpc_pkg::MsWidth-1:0]        csr_wdata
);
   import bdpc_pkg::*;

   cfg_type   cfg_ff,   cfg_in;
   state_type state_ff, state_in;
   state_type step_nxt;
   logic      step_pressed;
   logic      req_take;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_pressed_ff, rsp_pressed_in;
   flags_type rsp_flags_ff, rsp_flags_in;

   bdpc_step u_step (
      .cfg       (cfg_ff),
      .cur       (state_ff),
      .raw_level (req_raw_level),
      .now_ms    (req_now_ms),
      .nxt       (step_nxt),
      .pressed   (step_pressed)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cfg_in   = cfg_ff;
      state_in = state_ff;
      if (req_take) begin
         state_in = step_nxt;
      end
      if (csr_write) begin
         case (csr_index)
            CSR_ACTIVE_LEVEL: begin
               cfg_in.active_level = csr_wdata[0];
               state_in.level      = ~csr_wdata[0];
            end
            CSR_BOUNCE_MS:    cfg_in.bounce_ms = csr_wdata;
            CSR_SHORT_MS:     cfg_in.short_ms  = csr_wdata;
            CSR_LONG_MS:      cfg_in.long_ms   = csr_wdata;
            CSR_REPEAT_MS:    cfg_in.repeat_ms = csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_flags_in   = rsp_flags_ff;
      if (req_take) begin
         rsp_valid_in   = 1'b1;
         rsp_pressed_in = step_pressed;
         rsp_flags_in   = step_nxt.flags;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level <= ACTIVE_LEVEL_RST;
         cfg_ff.bounce_ms    <= BOUNCE_MS_RST;
         cfg_ff.short_ms     <= SHORT_MS_RST;
         cfg_ff.long_ms      <= LONG_MS_RST;
         cfg_ff.repeat_ms    <= REPEAT_MS_RST;
         state_ff.level       <= ~ACTIVE_LEVEL_RST;
         state_ff.last_change <= '0;
         state_ff.last_repeat <= '0;
         state_ff.flags       <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_flags_ff   <= rsp_flags_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pressed       = rsp_pressed_ff;
   assign rsp_just_pressed  = rsp_flags_ff.just_pressed;
   assign rsp_just_released = rsp_flags_ff.just_released;
   assign rsp_short_press   = rsp_flags_ff.short_press;
   assign rsp_long_press    = rsp_flags_ff.long_press;
   assign rsp_repeat_pulse  = rsp_flags_ff.repeat_pulse;

   // edges cannot both be reported
   a_one_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_flags_ff.just_pressed && rsp_flags_ff.just_released))
      else $error("press and release edge reported together");

   // a taken request always lands in the response register
   a_take_resp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("request taken without a response");

   // a stalled response is held while no new request can enter
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_flags_ff)
                                       && $stable(rsp_pressed_ff)))
      else $error("stalled response changed");

   // writing active_level marks the button released
   a_active_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == CSR_ACTIVE_LEVEL) |=>
         (state_ff.level != cfg_ff.active_level))
      else $error("active_level write did not release the button");

endmodule

### sim/tb_button_debounce_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// tb_button_debounce_press_classifier_unit
// Self-checking bench for the button debounce and press classifier. Press,
// hold and release sequences with chatter go in, mixed with random samples
// and clock jumps. Each accepted request is run through a local model of the
// debouncer. Every response is checked flag by flag against the model. The
// registers are rewritten between phases, the extreme values among them.
// ----------------------------------------------------------------------------
module tb_button_debounce_press_classifier_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bdpc_pkg::*;

   localparam logic [CsrIdxWidth-1:0] CSR_FIRST_UNUSED = CSR_REPEAT_MS + 3'd1;
   localparam int unsigned PHASE_SAMPLES = 115;
   localparam int NUM_PHASES = 14;

   typedef struct packed {
      logic                 raw_level;
      logic [TimeWidth-1:0] now_ms;
   } sample_type;

   typedef struct packed {
      logic      pressed;
      flags_type flags;
   } indication_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_raw_level = 1'b0;
   logic [TimeWidth-1:0]   req_now_ms = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_pressed;
   logic                   rsp_just_pressed;
   logic                   rsp_just_released;
   logic                   rsp_short_press;
   logic                   rsp_long_press;
   logic                   rsp_repeat_pulse;
   logic                   csr_write = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [MsWidth-1:0]     csr_wdata = '0;

   // debouncer model
   cfg_type              deb_cfg;
   logic                 deb_level;
   logic [TimeWidth-1:0] deb_last_change;
   logic [TimeWidth-1:0] deb_last_repeat;
   flags_type            deb_flags;

   sample_type     sample_q[$];
   indication_type pending_indication_q[$];
   sample_type     next_sample;
   int unsigned    samples_queued = 0;
   int unsigned    indications_seen = 0;
   int unsigned    mismatch_count = 0;
   int unsigned    idle_odds = 0;
   int unsigned    gap_left = 0;
   int unsigned    stall_left = 0;
   logic [TimeWidth-1:0] gen_time = '0;
   logic           gen_active = 1'b0;

   button_debounce_press_classifier_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_level     (req_raw_level),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pressed       (rsp_pressed),
      .rsp_just_pressed  (rsp_just_pressed),
      .rsp_just_released (rsp_just_released),
      .rsp_short_press   (rsp_short_press),
      .rsp_long_press    (rsp_long_press),
      .rsp_repeat_pulse  (rsp_repeat_pulse),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic void reset_debouncer();
      deb_cfg.active_level = ACTIVE_LEVEL_RST;
      deb_cfg.bounce_ms    = BOUNCE_MS_RST;
      deb_cfg.short_ms     = SHORT_MS_RST;
      deb_cfg.long_ms      = LONG_MS_RST;
      deb_cfg.repeat_ms    = REPEAT_MS_RST;
      deb_level            = ~ACTIVE_LEVEL_RST;
      deb_last_change      = '0;
      deb_last_repeat      = '0;
      deb_flags            = '0;
   endfunction

   function automatic void apply_reg(logic [CsrIdxWidth-1:0] idx, logic [MsWidth-1:0] data);
      case (idx)
         CSR_ACTIVE_LEVEL: begin
            deb_cfg.active_level = data[0];
            deb_level            = ~data[0];
         end
         CSR_BOUNCE_MS: deb_cfg.bounce_ms = data;
         CSR_SHORT_MS:  deb_cfg.short_ms  = data;
         CSR_LONG_MS:   deb_cfg.long_ms   = data;
         CSR_REPEAT_MS: deb_cfg.repeat_ms = data;
         default: ;
      endcase
   endfunction

   function automatic indication_type classify_sample(logic raw, logic [TimeWidth-1:0] now);
      logic [TimeWidth-1:0] held;
      logic [TimeWidth-1:0] since_repeat;
      logic                 was_pressed;
      logic                 is_pressed;
      logic                 bounced;
      indication_type       ind;
      held         = now - deb_last_change;
      since_repeat = now - deb_last_repeat;
      was_pressed  = (deb_level == deb_cfg.active_level);
      is_pressed   = (raw == deb_cfg.active_level);
      bounced      = 1'b0;
      if (raw != deb_level) begin
         if (held < TimeWidth'(deb_cfg.bounce_ms)) bounced = 1'b1;
         else deb_last_change = now;
      end
      if (!bounced) begin
         deb_flags.just_pressed  = 1'b0;
         deb_flags.just_released = 1'b0;
         if (!was_pressed && is_pressed) begin
            deb_flags.just_pressed = 1'b1;
         end else if (was_pressed && !is_pressed) begin
            deb_flags.just_released = 1'b1;
            if (held < TimeWidth'(deb_cfg.short_ms)) deb_flags.short_press = 1'b1;
            else if (held > TimeWidth'(deb_cfg.long_ms)) deb_flags.long_press = 1'b1;
         end else if (was_pressed && is_pressed) begin
            if (held > TimeWidth'(deb_cfg.long_ms)) begin
               deb_flags.repeat_pulse = 1'b0;
               if (since_repeat > TimeWidth'(deb_cfg.repeat_ms)) begin
                  deb_flags.repeat_pulse = 1'b1;
                  deb_last_repeat        = now;
               end
            end
         end else begin
            deb_flags.short_press  = 1'b0;
            deb_flags.long_press   = 1'b0;
            deb_flags.repeat_pulse = 1'b0;
         end
         deb_level = raw;
      end
      ind.pressed = (deb_level == deb_cfg.active_level);
      ind.flags   = deb_flags;
      return ind;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t ns] %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_response();
      indication_type want;
      indications_seen++;
      if (pending_indication_q.size() == 0) begin
         report_mismatch("response with no request outstanding");
         return;
      end
      want = pending_indication_q.pop_front();
      if (rsp_pressed !== want.pressed)
         report_mismatch($sformatf("pressed: expected %0b, got %0b", want.pressed, rsp_pressed));
      if (rsp_just_pressed !== want.flags.just_pressed)
         report_mismatch($sformatf("just_pressed: expected %0b, got %0b",
                                   want.flags.just_pressed, rsp_just_pressed));
      if (rsp_just_released !== want.flags.just_released)
         report_mismatch($sformatf("just_released: expected %0b, got %0b",
                                   want.flags.just_released, rsp_just_released));
      if (rsp_short_press !== want.flags.short_press)
         report_mismatch($sformatf("short_press: expected %0b, got %0b",
                                   want.flags.short_press, rsp_short_press));
      if (rsp_long_press !== want.flags.long_press)
         report_mismatch($sformatf("long_press: expected %0b, got %0b",
                                   want.flags.long_press, rsp_long_press));
      if (rsp_repeat_pulse !== want.flags.repeat_pulse)
         report_mismatch($sformatf("repeat_pulse: expected %0b, got %0b",
                                   want.flags.repeat_pulse, rsp_repeat_pulse));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            pending_indication_q.push_back(classify_sample(req_raw_level, req_now_ms));
         // hold a stalled request as it is
         if (!req_valid || !req_stall) begin
            if (gap_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               gap_left = $urandom_range(1, 4);
            if (gap_left != 0 || sample_q.size() == 0) begin
               if (gap_left != 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               next_sample = sample_q.pop_front();
               req_valid     <= 1'b1;
               req_raw_level <= next_sample.raw_level;
               req_now_ms    <= next_sample.now_ms;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_response();
         if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            stall_left = $urandom_range(1, 4);
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   task automatic push_sample(logic raw, logic [TimeWidth-1:0] now);
      sample_type s;
      s.raw_level = raw;
      s.now_ms    = now;
      sample_q.push_back(s);
      samples_queued++;
   endtask

   task automatic write_reg(logic [CsrIdxWidth-1:0] idx, logic [MsWidth-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      apply_reg(idx, data);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (indications_seen != samples_queued);
      repeat (3) @(negedge clock);
   endtask

   // press with chatter on both edges, a hold of about hold ms, then released samples
   task automatic queue_press(logic [MsWidth-1:0] bnc, int unsigned hold, int unsigned step);
      int unsigned held_for;
      repeat ($urandom_range(0, 3)) begin
         gen_time += $urandom_range(0, bnc / 4);
         push_sample(1'($urandom_range(0, 1)), gen_time);
      end
      gen_time += bnc + $urandom_range(0, step);
      push_sample(gen_active, gen_time);
      held_for = 0;
      while (held_for < hold) begin
         step = $urandom_range(1, step);
         gen_time += step;
         held_for += step;
         push_sample(gen_active, gen_time);
         step = (step * 2 > step) ? step * 2 : step;
      end
      gen_time += $urandom_range(0, step);
      push_sample(~gen_active, gen_time);
      repeat ($urandom_range(0, 3)) begin
         gen_time += $urandom_range(0, bnc / 4);
         push_sample(1'($urandom_range(0, 1)), gen_time);
      end
      gen_time += bnc + 1;
      push_sample(~gen_active, gen_time);
      repeat ($urandom_range(1, 3)) begin
         gen_time += $urandom_range(1, step);
         push_sample(~gen_active, gen_time);
      end
   endtask

   initial begin
      logic               act;
      logic [MsWidth-1:0] bnc;
      logic [MsWidth-1:0] shrt;
      logic [MsWidth-1:0] lng;
      logic [MsWidth-1:0] rpt;
      int unsigned        step;
      int unsigned        hold;
      int unsigned        phase_base;
      reset_debouncer();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default registers, pressed when the pin is low
      idle_odds = 3;
      push_sample(1'b1, 32'd0);            // released idle
      push_sample(1'b0, 32'd10);           // chatter inside the bounce time
      push_sample(1'b0, 32'd100);          // press
      push_sample(1'b0, 32'd200);          // held before long time
      push_sample(1'b1, 32'd300);          // short release
      push_sample(1'b1, 32'd310);          // released clears the flags
      push_sample(1'b0, 32'd400);
      push_sample(1'b1, 32'd1200);         // middle hold
      push_sample(1'b0, 32'd1300);
      push_sample(1'b0, 32'd2400);         // past long time, repeat fires
      push_sample(1'b0, 32'd2500);         // too soon for another repeat
      push_sample(1'b0, 32'd2700);
      push_sample(1'b1, 32'd2800);         // long release keeps repeat
      push_sample(1'b1, 32'd2810);
      push_sample(1'b0, 32'hFFFF_FFF0);
      push_sample(1'b1, 32'h0000_0004);    // release chatter across the wrap
      push_sample(1'b0, 32'h0000_0400);
      push_sample(1'b1, 32'h0000_0500);
      push_sample(1'b1, 32'hFFFF_FFFF);
      push_sample(1'b0, 32'h0000_0600);
      push_sample(1'b1, 32'h0000_07F4);    // hold equal to short time
      push_sample(1'b0, 32'h0000_0826);    // change exactly at the bounce time
      push_sample(1'b1, 32'h0000_0C0E);    // hold equal to long time
      push_sample(1'b1, 32'h0000_0C10);
      wait_drained();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               act = 1'b0; bnc = '0; shrt = '0; lng = '0; rpt = '0;
            end
            1: begin
               act = 1'b1; bnc = '1; shrt = '1; lng = '1; rpt = '1;
            end
            2: begin
               // short time above long time
               act = 1'($urandom_range(0, 1)); bnc = '0; shrt = '1; lng = '0; rpt = '0;
            end
            default: begin
               act  = 1'($urandom_range(0, 1));
               bnc  = MsWidth'($urandom_range(0, 40));
               shrt = MsWidth'($urandom_range(0, 300));
               lng  = shrt + MsWidth'($urandom_range(0, 400));
               rpt  = MsWidth'($urandom_range(0, 150));
            end
         endcase
         if (phase >= NUM_PHASES - 3 || phase % 4 == 3) idle_odds = 0;
         else idle_odds = $urandom_range(2, 10);

         if ($urandom_range(0, 1))
            write_reg(CsrIdxWidth'($urandom_range(CSR_FIRST_UNUSED, {CsrIdxWidth{1'b1}})),
                      MsWidth'($urandom));
         write_reg(CSR_BOUNCE_MS, bnc);
         write_reg(CSR_SHORT_MS, shrt);
         write_reg(CSR_LONG_MS, lng);
         write_reg(CSR_REPEAT_MS, rpt);
         write_reg(CSR_ACTIVE_LEVEL, {(MsWidth-1)'($urandom), act});
         @(negedge clock);

         gen_active = act;
         gen_time   = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3000);
         step       = (int'(lng) + int'(rpt)) / 12 + 1;
         phase_base = samples_queued;
         while (samples_queued - phase_base < PHASE_SAMPLES) begin
            if ($urandom_range(0, 6) == 0) begin
               // noise, sometimes with a jump anywhere on the clock
               if ($urandom_range(0, 1)) gen_time = $urandom;
               else gen_time += $urandom_range(0, 3 * step);
               push_sample(1'($urandom_range(0, 1)), gen_time);
            end else begin
               case ($urandom_range(0, 2))
                  0:       hold = $urandom_range(0, shrt);
                  1:       hold = $urandom_range(shrt, lng);
                  default: hold = lng + $urandom_range(1, 4 * rpt + step);
               endcase
               queue_press(bnc, hold, step);
            end
         end
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (pending_indication_q.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_indication_q.size()));
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("run timed out");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
